// ===== src/bmp_pkg.sv =====
// ----------------------------------------------------------------------------
// bmp_pkg - shared constants and types for the binomial mod prime block
// Holds the modulus, the Barrett reduction constant, the init sequencer
// states and the table write strobes.
// ----------------------------------------------------------------------------
package bmp_pkg;

    localparam int unsigned VAL_W = 30;

    // Modulus and exponent for the Fermat inverse
    localparam logic [VAL_W-1:0] PRIME   = 30'd1000000007;
    localparam logic [VAL_W-1:0] POW_EXP = 30'd1000000005;

    // Barrett constant floor(2^60 / p), 31 bits wide
    localparam logic [63:0] MU_FULL    = (64'd1 << 60) / 64'd1000000007;
    localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

    // Table fill sequencer states
    typedef enum logic [2:0] {
        INIT_START,
        INIT_FACT,
        INIT_POW,
        INIT_INV,
        INIT_DONE
    } init_state_t;

    // Sub-phase of a multiply request inside the sequencer
    typedef enum logic [1:0] {
        PH_ISSUE,
        PH_SQUARE,
        PH_WAIT
    } mul_phase_t;

    // Table write strobes
    typedef struct packed {
        logic fact_we;
        logic invf_we;
    } tbl_wr_t;

endpackage

// ===== src/bmp_if.sv =====
// ----------------------------------------------------------------------------
// bmp_if - query and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bmp_query_if;
    logic        valid;
    logic        ready;
    logic [15:0] n_value;
    logic [15:0] r_value;

    modport source (output valid, output n_value, output r_value, input ready);
    modport sink   (input valid, input n_value, input r_value, output ready);
endinterface

interface bmp_result_if;
    logic        valid;
    logic        ready;
    logic [29:0] binomial;

    modport source (output valid, output binomial, input ready);
    modport sink   (input valid, input binomial, output ready);
endinterface

// ===== src/bmp_mulmod.sv =====
// ----------------------------------------------------------------------------
// bmp_mulmod - pipelined multiply modulo 1000000007
// Five stages: product, Barrett quotient estimate, remainder, two
// conditional subtracts. A tag rides along with each beat.
// ----------------------------------------------------------------------------
module bmp_mulmod
    import bmp_pkg::*;
#(
    parameter int TAG_W = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [29:0]      a,
    input  logic [29:0]      b,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    output logic [29:0]      res,
    output logic [TAG_W-1:0] tag_out
);

    logic [4:0]       vld_reg;
    logic [TAG_W-1:0] tag_reg [5];
    logic [59:0]      prod_reg;
    logic [61:0]      qh_reg;
    logic [31:0]      x2_reg;
    logic [31:0]      r3_reg;
    logic [31:0]      r4_reg;
    logic [29:0]      r5_reg;

    logic [30:0] q_est;
    logic [31:0] qp_low;
    logic [31:0] r4_next;
    logic [31:0] r5_full;

    // Quotient times modulus, low word only: remainder stays below 3p
    assign q_est   = qh_reg[61:31];
    assign qp_low  = 32'(32'(q_est) * 32'(PRIME));
    assign r4_next = (r3_reg >= 32'(PRIME)) ? (r3_reg - 32'(PRIME)) : r3_reg;
    assign r5_full = (r4_reg >= 32'(PRIME)) ? (r4_reg - 32'(PRIME)) : r4_reg;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= 60'(a) * 60'(b);
            tag_reg[0] <= tag_in;
            qh_reg     <= 62'(prod_reg[59:29]) * 62'(BARRETT_MU);
            x2_reg     <= prod_reg[31:0];
            tag_reg[1] <= tag_reg[0];
            r3_reg     <= x2_reg - qp_low;
            tag_reg[2] <= tag_reg[1];
            r4_reg     <= r4_next;
            tag_reg[3] <= tag_reg[2];
            r5_reg     <= r5_full[29:0];
            tag_reg[4] <= tag_reg[3];
        end
    end

    assign out_valid = vld_reg[4];
    assign res       = r5_reg;
    assign tag_out   = tag_reg[4];

endmodule

// ===== src/bmp_init.sv =====
// ----------------------------------------------------------------------------
// bmp_init - table fill sequencer
// Fills the factorial table upward, inverts the last factorial by
// square-and-multiply, then fills the inverse factorial table downward.
// ----------------------------------------------------------------------------
module bmp_init
    import bmp_pkg::*;
#(
    parameter int ADDR_W = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    output tbl_wr_t           wr,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [29:0]       wr_data,
    output logic              done
);

    init_state_t       state_reg, state_next;
    mul_phase_t        phase_reg, phase_next;
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [29:0]       acc_reg, acc_next;
    logic [29:0]       sq_reg, sq_next;
    logic [29:0]       exp_reg, exp_next;

    logic        mm_valid;
    logic [29:0] mm_a;
    logic [29:0] mm_b;
    logic        mm_tag;
    logic        mm_out_valid;
    logic [29:0] mm_res;
    logic        mm_out_tag;

    bmp_mulmod #(.TAG_W(1)) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (1'b1),
        .in_valid  (mm_valid),
        .a         (mm_a),
        .b         (mm_b),
        .tag_in    (mm_tag),
        .out_valid (mm_out_valid),
        .res       (mm_res),
        .tag_out   (mm_out_tag)
    );

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= INIT_START;
            phase_reg <= PH_ISSUE;
            i_reg     <= '0;
            acc_reg   <= '0;
            sq_reg    <= '0;
            exp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            i_reg     <= i_next;
            acc_reg   <= acc_next;
            sq_reg    <= sq_next;
            exp_reg   <= exp_next;
        end
    end

    // Sequence the multiplies and table writes
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        i_next     = i_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        exp_next   = exp_reg;
        mm_valid   = 1'b0;
        mm_a       = acc_reg;
        mm_b       = 30'(i_reg);
        mm_tag     = 1'b0;
        wr         = '0;
        wr_addr    = i_reg;
        wr_data    = mm_res;

        case (state_reg)
            INIT_START:
            begin
                // Seed 0! = 1
                wr.fact_we = 1'b1;
                wr_addr    = '0;
                wr_data    = 30'd1;
                acc_next   = 30'd1;
                i_next     = ADDR_W'(1);
                phase_next = PH_ISSUE;
                state_next = INIT_FACT;
            end

            INIT_FACT:
            begin
                if (phase_reg == PH_ISSUE)
                begin
                    mm_valid   = 1'b1;
                    phase_next = PH_WAIT;
                end
                else if (mm_out_valid)
                begin
                    wr.fact_we = 1'b1;
                    acc_next   = mm_res;
                    phase_next = PH_ISSUE;
                    if (&i_reg)
                    begin
                        sq_next    = mm_res;
                        acc_next   = 30'd1;
                        exp_next   = POW_EXP;
                        state_next = INIT_POW;
                    end
                    else
                    begin
                        i_next = i_reg + ADDR_W'(1);
                    end
                end
            end

            INIT_POW:
            begin
                case (phase_reg)
                    PH_ISSUE:
                    begin
                        // Multiply the accumulator by the square or by one
                        mm_valid   = 1'b1;
                        mm_b       = exp_reg[0] ? sq_reg : 30'd1;
                        phase_next = PH_SQUARE;
                    end
                    PH_SQUARE:
                    begin
                        mm_valid   = 1'b1;
                        mm_a       = sq_reg;
                        mm_b       = sq_reg;
                        mm_tag     = 1'b1;
                        phase_next = PH_WAIT;
                    end
                    default:
                    begin
                        if (mm_out_valid && !mm_out_tag)
                        begin
                            acc_next = mm_res;
                        end
                        else if (mm_out_valid)
                        begin
                            sq_next    = mm_res;
                            exp_next   = exp_reg >> 1;
                            phase_next = PH_ISSUE;
                            if (exp_reg[29:1] == '0)
                            begin
                                // Last inverse factorial
                                wr.invf_we = 1'b1;
                                wr_data    = acc_reg;
                                i_next     = '1;
                                state_next = INIT_INV;
                            end
                        end
                    end
                endcase
            end

            INIT_INV:
            begin
                wr_addr = i_reg - ADDR_W'(1);
                if (phase_reg == PH_ISSUE)
                begin
                    mm_valid   = 1'b1;
                    phase_next = PH_WAIT;
                end
                else if (mm_out_valid)
                begin
                    wr.invf_we = 1'b1;
                    acc_next   = mm_res;
                    phase_next = PH_ISSUE;
                    i_next     = i_reg - ADDR_W'(1);
                    if (i_reg == ADDR_W'(1))
                    begin
                        state_next = INIT_DONE;
                    end
                end
            end

            default:
            begin
                state_next = INIT_DONE;
            end
        endcase
    end

    assign done = (state_reg == INIT_DONE);

endmodule

// ===== src/bmp_front.sv =====
// ----------------------------------------------------------------------------
// bmp_front - query intake
// Takes query beats once the tables are ready, flags queries whose answer
// is zero, forms the three table addresses and queues them.
// ----------------------------------------------------------------------------
module bmp_front #(
    parameter int ADDR_W = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    bmp_query_if.sink         query,
    input  logic              init_done,
    output logic              q_valid,
    output logic              q_zero,
    output logic [ADDR_W-1:0] q_n,
    output logic [ADDR_W-1:0] q_r,
    output logic [ADDR_W-1:0] q_d,
    input  logic              q_pop
);

    localparam int unsigned MAX_N = (1 << ADDR_W) - 1;
    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    logic              zero_mem [DEPTH];
    logic [ADDR_W-1:0] n_mem    [DEPTH];
    logic [ADDR_W-1:0] r_mem    [DEPTH];
    logic [ADDR_W-1:0] d_mem    [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;

    logic        push;
    logic        zero_flag;
    logic [15:0] diff;

    // Classify the query
    assign diff      = query.n_value - query.r_value;
    assign zero_flag = (query.n_value < query.r_value) || (32'(query.n_value) > MAX_N);

    assign query.ready = init_done && (cnt_reg != (PTR_W+1)'(DEPTH));
    assign push        = query.valid && query.ready;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the queued beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            zero_mem[wr_ptr_reg] <= zero_flag;
            n_mem[wr_ptr_reg]    <= ADDR_W'(query.n_value);
            r_mem[wr_ptr_reg]    <= ADDR_W'(query.r_value);
            d_mem[wr_ptr_reg]    <= ADDR_W'(diff);
        end
    end

    assign q_valid = (cnt_reg != '0);
    assign q_zero  = zero_mem[rd_ptr_reg];
    assign q_n     = n_mem[rd_ptr_reg];
    assign q_r     = r_mem[rd_ptr_reg];
    assign q_d     = d_mem[rd_ptr_reg];

endmodule

// ===== src/bmp_back.sv =====
// ----------------------------------------------------------------------------
// bmp_back - table storage and query evaluation
// Holds both tables, reads three entries per query and forms
// fact[n] * invf[r] * invf[n-r] mod p through two multiply pipelines.
// ----------------------------------------------------------------------------
module bmp_back
    import bmp_pkg::*;
#(
    parameter int ADDR_W = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tbl_wr_t           wr,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [29:0]       wr_data,
    input  logic              q_valid,
    input  logic              q_zero,
    input  logic [ADDR_W-1:0] q_n,
    input  logic [ADDR_W-1:0] q_r,
    input  logic [ADDR_W-1:0] q_d,
    output logic              q_pop,
    bmp_result_if.source      result
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [29:0] fact_mem [DEPTH];
    logic [29:0] invf_mem [DEPTH];

    logic        en;
    logic        s1_valid_reg;
    logic        s1_zero_reg;
    logic [29:0] fact_rd_reg;
    logic [29:0] invr_rd_reg;
    logic [29:0] invd_rd_reg;

    logic        a_valid;
    logic [29:0] a_res;
    logic [30:0] a_tag;
    logic        b_valid;
    logic [29:0] b_res;
    logic        b_tag;

    logic        out_valid_reg;
    logic [29:0] binomial_reg;

    // Advance the whole pipe unless the output beat is stalled
    assign en    = !out_valid_reg || result.ready;
    assign q_pop = en && q_valid;

    // Write the tables during the fill
    always_ff @(posedge clk)
    begin
        if (wr.fact_we)
        begin
            fact_mem[wr_addr] <= wr_data;
        end
        if (wr.invf_we)
        begin
            invf_mem[wr_addr] <= wr_data;
        end
    end

    // Read the three entries
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fact_rd_reg <= fact_mem[q_n];
            invr_rd_reg <= invf_mem[q_r];
            invd_rd_reg <= invf_mem[q_d];
            s1_zero_reg <= q_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= q_valid;
            out_valid_reg <= b_valid;
        end
    end

    bmp_mulmod #(.TAG_W(31)) u_mul_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .a         (fact_rd_reg),
        .b         (invr_rd_reg),
        .tag_in    ({s1_zero_reg, invd_rd_reg}),
        .out_valid (a_valid),
        .res       (a_res),
        .tag_out   (a_tag)
    );

    bmp_mulmod #(.TAG_W(1)) u_mul_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_valid),
        .a         (a_res),
        .b         (a_tag[29:0]),
        .tag_in    (a_tag[30]),
        .out_valid (b_valid),
        .res       (b_res),
        .tag_out   (b_tag)
    );

    // Hold the result beat, forced to zero for flagged queries
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            binomial_reg <= b_tag ? 30'd0 : b_res;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.binomial = binomial_reg;

endmodule

// ===== src/binomial_mod_prime.sv =====
// ----------------------------------------------------------------------------
// binomial_mod_prime - n choose r modulo 1000000007
//
//   channel   dir   beat fields
//   query     in    n_value[15:0], r_value[15:0]
//   result    out   binomial[29:0]
//
// After reset the tables fill (one dependent modular multiply per entry,
// both tables, plus the exponentiation); query.ready stays low until then.
// Afterwards one query is taken per cycle while the result is not stalled;
// each answer passes through the table read, two five-stage multiply
// pipelines and the result register.
// A stalled result holds the pipe; a four-entry queue keeps taking queries.
// ----------------------------------------------------------------------------
module binomial_mod_prime
    import bmp_pkg::*;
#(
    parameter int ADDR_W = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    bmp_query_if.sink     query,
    bmp_result_if.source  result
);

    tbl_wr_t           wr;
    logic [ADDR_W-1:0] wr_addr;
    logic [29:0]       wr_data;
    logic              init_done;

    logic              q_valid;
    logic              q_zero;
    logic [ADDR_W-1:0] q_n;
    logic [ADDR_W-1:0] q_r;
    logic [ADDR_W-1:0] q_d;
    logic              q_pop;

    bmp_init #(.ADDR_W(ADDR_W)) u_init (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .done    (init_done)
    );

    bmp_front #(.ADDR_W(ADDR_W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .query     (query),
        .init_done (init_done),
        .q_valid   (q_valid),
        .q_zero    (q_zero),
        .q_n       (q_n),
        .q_r       (q_r),
        .q_d       (q_d),
        .q_pop     (q_pop)
    );

    bmp_back #(.ADDR_W(ADDR_W)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .q_valid (q_valid),
        .q_zero  (q_zero),
        .q_n     (q_n),
        .q_r     (q_r),
        .q_d     (q_d),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule
